[hw/rtl/msbp_pkg.sv]
// ----------------------------------------------------------------------------
// msbp_pkg: shared types and constants of the msb-first bit stack packer
// Item and result layouts, command and status codes, and the control and
// status groups between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package msbp_pkg;

	// store geometry
	localparam int DEF_STORE_WORDS = 64;
	localparam int WORD_BITS       = 32;
	localparam int OFF_W           = $clog2(WORD_BITS);

	// field widths
	localparam int CMD_W    = 2;
	localparam int LEN_W    = 6;
	localparam int IDX_W    = 11;
	localparam int FILL_W   = 12;
	localparam int STATUS_W = 3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd4;

	// one input item
	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [WORD_BITS-1:0] code_bits;
		logic [LEN_W-1:0]     code_length;
		logic [IDX_W-1:0]     read_index;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic                 read_bit;
		logic                 top_bit;
		logic [FILL_W-1:0]    fill_count;
		logic                 is_empty;
		logic [STATUS_W-1:0]  status;
	} out_item_t;

	// sequencer to datapath
	typedef struct packed {
		logic load;
		logic ram_rd;
		logic merge;
		logic wr_w1;
		logic finish;
	} ctrl_cmd_t;

	// datapath to sequencer
	typedef struct packed {
		logic needs_read;
		logic spill;
	} ctrl_sts_t;

endpackage

[hw/rtl/msb_first_bit_stack_packer.sv]
// ----------------------------------------------------------------------------
// msb_first_bit_stack_packer: msb-first bit stack for variable-length codes
// Packs pushed codes into a word store, pops, reads and clears bits, and
// returns fill size, top bit and status for every item.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. Clear, a pop of the only
// bit held and every rejected command pass through the exec and done steps
// only; any other pop, a read and a push that stays in one word add a word
// read and a merge step, and a push that crosses into the next word adds a
// spill step as well: the single-port word store is read once before a push
// merges into the partly filled word, and a spilling push writes the second
// word in a step of its own. A finished result waits in an output register
// while the next item is taken. Clear resets the bit count and top bit only;
// store bits at or above the fill point are never returned, so no clearing pass runs after reset or clear.
module msb_first_bit_stack_packer
	import msbp_pkg::*;
#(
	parameter int STORE_WORDS = DEF_STORE_WORDS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer
	msbp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath with word store
	msbp_dpath #(
		.STORE_WORDS (STORE_WORDS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

[hw/rtl/msbp_ram.sv]
// ----------------------------------------------------------------------------
// msbp_ram: generic single-port ram
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
module msbp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write or registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/msbp_ctrl.sv]
// ----------------------------------------------------------------------------
// msbp_ctrl: sequencer of the msb-first bit stack packer
// Steps each item through word read, merge (bit pick or merge write), spill
// write and result delivery, and owns the result valid flag.
// ----------------------------------------------------------------------------
module msbp_ctrl
	import msbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	output logic      result_valid,
	input  logic      result_stall,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_MERGE = 3'd2;
	localparam logic [2:0] S_SPILL = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       result_valid_q;

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load   = 1'b1;
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.needs_read) begin
					cmd.ram_rd = 1'b1;
					state_next = S_MERGE;
				end else begin
					state_next = S_DONE;
				end
			end
			S_MERGE: begin
				cmd.merge  = 1'b1;
				state_next = sts.spill ? S_SPILL : S_DONE;
			end
			S_SPILL: begin
				cmd.wr_w1  = 1'b1;
				state_next = S_DONE;
			end
			S_DONE: begin
				if (!result_valid_q || !result_stall) begin
					cmd.finish = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// result valid: set on finish, dropped after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

endmodule

[hw/rtl/msbp_dpath.sv]
// ----------------------------------------------------------------------------
// msbp_dpath: datapath of the msb-first bit stack packer
// Holds the item, the bit count and the top bit, checks each command, and
// merges pushed codes into the word store by read-modify-write.
// ----------------------------------------------------------------------------
module msbp_dpath
	import msbp_pkg::*;
#(
	parameter int STORE_WORDS = DEF_STORE_WORDS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  ctrl_cmd_t cmd,
	output ctrl_sts_t sts,
	output out_item_t result
);

	localparam int AW     = $clog2(STORE_WORDS);
	localparam int CAP    = STORE_WORDS * WORD_BITS;
	localparam int CNT_W  = $clog2(CAP + 1);
	localparam int XW     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int DW     = 2 * WORD_BITS;
	localparam int SH_W   = OFF_W + 2;
	localparam logic [CNT_W:0] CAP_C = (CNT_W + 1)'(CAP);

	in_item_t             item_q;
	logic [CNT_W-1:0]     count_q;
	logic                 top_q;
	logic                 bit_q;
	out_item_t            result_q;

	logic                 is_push;
	logic                 is_pop;
	logic                 is_read;
	logic                 is_clear;
	logic [LEN_W-1:0]     len;
	logic [OFF_W-1:0]     off;
	logic                 bad_len;
	logic                 ovf;
	logic [XW-1:0]        idx_x;
	logic [XW-1:0]        cnt_x;
	logic [CNT_W-1:0]     cnt_m2;
	logic                 push_ok;
	logic                 pop_ok;
	logic                 read_ok;
	logic [STATUS_W-1:0]  status;
	logic [XW-1:0]        pos_x;
	logic [OFF_W-1:0]     rd_off;
	logic [AW-1:0]        w0_addr;
	logic [SH_W-1:0]      sh;
	logic [DW-1:0]        mask;
	logic [DW-1:0]        shifted;
	logic [DW-1:0]        smask;
	logic                 spill;
	logic [WORD_BITS-1:0] w0_new;
	logic [WORD_BITS-1:0] rd_data;
	logic                 ram_en;
	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [CNT_W-1:0]     cnt_next;
	logic                 top_next;

	// command decode and checks
	always_comb begin
		is_push  = (item_q.cmd == CMD_PUSH);
		is_pop   = (item_q.cmd == CMD_POP);
		is_read  = (item_q.cmd == CMD_READ);
		is_clear = (item_q.cmd == CMD_CLEAR);
		len      = item_q.code_length;
		off      = count_q[OFF_W-1:0];
		bad_len  = (len == '0) || (len > LEN_W'(WORD_BITS));
		ovf      = ({1'b0, count_q} + (CNT_W + 1)'(len)) > CAP_C;
		idx_x    = XW'(item_q.read_index);
		cnt_x    = XW'(count_q);
		cnt_m2   = count_q - CNT_W'(2);
		push_ok  = is_push && !bad_len && !ovf;
		pop_ok   = is_pop && (count_q != '0);
		read_ok  = is_read && (idx_x < cnt_x);
	end

	// status code
	always_comb begin
		status = ST_OK;
		priority if (is_push && bad_len) begin
			status = ST_BAD_LENGTH;
		end else if (is_push && ovf) begin
			status = ST_OVERFLOW;
		end else if (is_pop && !pop_ok) begin
			status = ST_POP_EMPTY;
		end else if (is_read && !read_ok) begin
			status = ST_RANGE;
		end else begin
			status = ST_OK;
		end
	end

	// bit position that the word read serves
	always_comb begin
		priority if (read_ok) begin
			pos_x = idx_x;
		end else if (push_ok) begin
			pos_x = cnt_x;
		end else begin
			pos_x = XW'(cnt_m2);
		end
		rd_off  = pos_x[OFF_W-1:0];
		w0_addr = cnt_x[AW+OFF_W-1:OFF_W];
	end

	// align the masked code below the fill point across two words
	always_comb begin
		sh      = SH_W'(DW) - SH_W'(off) - SH_W'(len);
		mask    = (DW'(1) << len) - DW'(1);
		shifted = (DW'(item_q.code_bits) & mask) << sh;
		smask   = mask << sh;
		spill   = (SH_W'(off) + SH_W'(len)) > SH_W'(WORD_BITS);
		w0_new  = (rd_data & ~smask[DW-1:WORD_BITS]) | shifted[DW-1:WORD_BITS];
	end

	assign sts.needs_read = push_ok || read_ok || (pop_ok && (count_q > CNT_W'(1)));
	assign sts.spill      = push_ok && spill;

	// store port: read, merged first word, spilled second word
	always_comb begin
		ram_we    = (cmd.merge && push_ok) || cmd.wr_w1;
		ram_en    = cmd.ram_rd || ram_we;
		ram_wdata = cmd.wr_w1 ? shifted[WORD_BITS-1:0] : w0_new;
		priority if (cmd.ram_rd) begin
			ram_addr = pos_x[AW+OFF_W-1:OFF_W];
		end else if (cmd.wr_w1) begin
			ram_addr = w0_addr + AW'(1);
		end else begin
			ram_addr = w0_addr;
		end
	end

	msbp_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (rd_data)
	);

	// count and top bit after this item
	always_comb begin
		cnt_next = count_q;
		top_next = top_q;
		priority if (push_ok) begin
			cnt_next = count_q + CNT_W'(len);
			top_next = item_q.code_bits[0];
		end else if (pop_ok) begin
			cnt_next = count_q - CNT_W'(1);
			top_next = (count_q > CNT_W'(1)) ? bit_q : 1'b0;
		end else if (is_clear) begin
			cnt_next = '0;
			top_next = 1'b0;
		end else begin
			cnt_next = count_q;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// bit picked from the word read
	always_ff @(posedge clk) begin
		if (cmd.merge) begin
			bit_q <= rd_data[~rd_off];
		end
	end

	// stack state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			top_q   <= 1'b0;
		end else if (cmd.finish) begin
			count_q <= cnt_next;
			top_q   <= top_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.read_bit   <= read_ok ? bit_q : 1'b0;
			result_q.top_bit    <= top_next;
			result_q.fill_count <= FILL_W'(cnt_next);
			result_q.is_empty   <= (cnt_next == '0);
			result_q.status     <= status;
		end
	end

	assign result = result_q;

endmodule

[dv/tb_msb_first_bit_stack_packer.sv]
// ----------------------------------------------------------------------------
// tb_msb_first_bit_stack_packer: self-checking bench for the msb-first bit stack
// A directed opening hits empty-stack errors, bad lengths, word-crossing
// pushes, masking and range edges. Random episodes then fill the stack, often
// to overflow, read it back, pop it down and clear it. Every result is compared
// field by field against an in-bench model of the stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_msb_first_bit_stack_packer;
	import msbp_pkg::*;

	localparam int CLK_NS          = 12;
	localparam int WATCHDOG_CYCLES = 600000;
	localparam int STACK_WORDS     = DEF_STORE_WORDS;
	localparam int CAP_BITS        = STACK_WORDS * WORD_BITS;
	localparam int RANDOM_OPS      = 700;
	localparam int TAIL_OPS        = 100;
	localparam int LONG_HOLD_AT    = 300;
	localparam int LONG_HOLD_LEN   = 120;

	typedef struct {
		in_item_t op;
		bit       settle_first;
	} planned_op_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_stall;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	// stimulus backlog and results owed by the block
	planned_op_t op_backlog[$];
	out_item_t   bitstack_replies[$];

	// model of the stack
	logic [WORD_BITS-1:0] stack_words [STACK_WORDS];
	int                   held_bits;

	int n_total;
	int n_sent;
	int n_recv;
	int fail_count;
	int send_gap;
	int hold_left;
	bit long_hold_done;
	bit quiet_tail;
	int gen_fill;
	int op_tally [4];
	int status_tally [5];

	msb_first_bit_stack_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #(CLK_NS / 2) clk = ~clk;
	end

	initial begin
		#(WATCHDOG_CYCLES * CLK_NS);
		$display("Regression FAIL");
		$finish;
	end

	// apply one command to the model stack and return the reply it owes
	function automatic out_item_t bitstack_apply(input in_item_t op);
		out_item_t r;
		int        len;
		int        pos;
		r = '0;
		r.status = ST_OK;
		len = op.code_length;
		case (op.cmd)
			CMD_PUSH: begin
				if (len == 0 || len > WORD_BITS) begin
					r.status = ST_BAD_LENGTH;
				end else if (len > CAP_BITS - held_bits) begin
					r.status = ST_OVERFLOW;
				end else begin
					// msb of the code goes first, words fill from bit 31 down
					for (int k = 0; k < len; k++) begin
						pos = held_bits + k;
						stack_words[pos / WORD_BITS][WORD_BITS - 1 - pos % WORD_BITS] =
							op.code_bits[len - 1 - k];
					end
					held_bits += len;
				end
			end
			CMD_POP: begin
				if (held_bits == 0) begin
					r.status = ST_POP_EMPTY;
				end else begin
					held_bits -= 1;
					stack_words[held_bits / WORD_BITS][WORD_BITS - 1 - held_bits % WORD_BITS] =
						1'b0;
				end
			end
			CMD_READ: begin
				pos = op.read_index;
				if (pos >= held_bits)
					r.status = ST_RANGE;
				else
					r.read_bit = stack_words[pos / WORD_BITS][WORD_BITS - 1 - pos % WORD_BITS];
			end
			CMD_CLEAR: begin
				foreach (stack_words[w])
					stack_words[w] = '0;
				held_bits = 0;
			end
		endcase
		if (held_bits != 0) begin
			pos = held_bits - 1;
			r.top_bit = stack_words[pos / WORD_BITS][WORD_BITS - 1 - pos % WORD_BITS];
		end
		r.fill_count = held_bits[FILL_W-1:0];
		r.is_empty   = (held_bits == 0);
		op_tally[op.cmd] += 1;
		status_tally[r.status] += 1;
		return r;
	endfunction

	// queue one planned command and track the fill it leads to
	task automatic add_op(input logic [CMD_W-1:0] cmd, input logic [WORD_BITS-1:0] bits,
			input int len, input int idx, input bit settle);
		planned_op_t p;
		p.op.cmd         = cmd;
		p.op.code_bits   = bits;
		p.op.code_length = len[LEN_W-1:0];
		p.op.read_index  = idx[IDX_W-1:0];
		p.settle_first   = settle;
		op_backlog.insert(op_backlog.size(), p);
		case (cmd)
			CMD_PUSH: begin
				if (len >= 1 && len <= WORD_BITS && len <= CAP_BITS - gen_fill)
					gen_fill += len;
			end
			CMD_POP: begin
				if (gen_fill > 0)
					gen_fill -= 1;
			end
			CMD_CLEAR: gen_fill = 0;
			default: ;
		endcase
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// sender: offers planned commands, idles in bursts, pauses to let results drain
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			send_gap   <= 0;
			n_sent     <= 0;
		end else begin
			planned_op_t nxt;
			bit          took;
			took = item_valid && !item_stall;
			if (took) begin
				bitstack_replies.insert(bitstack_replies.size(), bitstack_apply(item));
				n_sent <= n_sent + 1;
			end
			if (!item_valid || took) begin
				if (send_gap > 0) begin
					item_valid <= 1'b0;
					send_gap   <= send_gap - 1;
				end else if (op_backlog.size() == 0) begin
					item_valid <= 1'b0;
				end else if (op_backlog[0].settle_first && (n_sent + took != n_recv)) begin
					item_valid <= 1'b0;
				end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
					item_valid <= 1'b0;
					send_gap   <= $urandom_range(0, 15);
				end else begin
					nxt = op_backlog.pop_front();
					item       <= nxt.op;
					item_valid <= 1'b1;
				end
			end
		end
	end

	// receiver: checks every result transfer and drives the stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall   <= 1'b0;
			hold_left      <= 0;
			long_hold_done <= 1'b0;
			n_recv         <= 0;
		end else begin
			out_item_t want;
			if (result_valid && !result_stall) begin
				n_recv <= n_recv + 1;
				if (bitstack_replies.size() == 0) begin
					$error("result transfer with nothing owed: fill_count %0d status %0d",
						result.fill_count, result.status);
					fail_count++;
				end else begin
					want = bitstack_replies.pop_front();
					check_field("read_bit", want.read_bit, result.read_bit);
					check_field("top_bit", want.top_bit, result.top_bit);
					check_field("fill_count", want.fill_count, result.fill_count);
					check_field("is_empty", want.is_empty, result.is_empty);
					check_field("status", want.status, result.status);
				end
			end
			// one long hold-off so the block backs up into its input
			if (!long_hold_done && n_recv == LONG_HOLD_AT) begin
				result_stall   <= 1'b1;
				hold_left      <= LONG_HOLD_LEN - 1;
				long_hold_done <= 1'b1;
			end else if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left    <= hold_left - 1;
			end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
				result_stall <= 1'b1;
				hold_left    <= $urandom_range(0, 15);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// no idling on either side over the last stretch
	always @(posedge clk)
		quiet_tail <= (n_total > 0) && (n_sent + TAIL_OPS >= n_total);

	initial begin
		int mode;
		int cnt;
		int len;
		int idx;
		int target;
		bit settle;
		bit hit_full;

		fail_count = 0;
		held_bits  = 0;
		gen_fill   = 0;
		n_total    = 0;
		foreach (stack_words[w])
			stack_words[w] = '0;
		foreach (op_tally[i])
			op_tally[i] = 0;
		foreach (status_tally[i])
			status_tally[i] = 0;

		// directed opening: empty-stack errors, lengths, crossings, range edges
		add_op(CMD_POP, 32'hFFFF_FFFF, 63, 2047, 0);
		add_op(CMD_READ, 32'hFFFF_FFFF, 32, 0, 0);
		add_op(CMD_PUSH, 32'hFFFF_FFFF, 0, 2047, 0);
		add_op(CMD_PUSH, 32'hFFFF_FFFF, 33, 0, 0);
		add_op(CMD_PUSH, 32'h1234_5678, 63, 0, 0);
		add_op(CMD_PUSH, 32'hFFFF_FFFF, 1, 0, 0);
		add_op(CMD_READ, 32'h0, 0, 0, 0);
		add_op(CMD_PUSH, 32'hFFFF_FFFF, 32, 0, 0);
		add_op(CMD_PUSH, 32'h0000_0000, 31, 0, 0);
		add_op(CMD_PUSH, 32'hFFFF_FFF5, 5, 0, 0);
		add_op(CMD_PUSH, 32'h8000_0001, 32, 2047, 0);
		add_op(CMD_READ, 32'h0, 0, 32, 0);
		add_op(CMD_READ, 32'h0, 0, 33, 0);
		add_op(CMD_READ, 32'h0, 0, gen_fill - 1, 0);
		add_op(CMD_READ, 32'h0, 0, gen_fill, 0);
		add_op(CMD_READ, 32'hFFFF_FFFF, 63, 2047, 0);
		add_op(CMD_POP, 32'hFFFF_FFFF, 0, 2047, 0);
		add_op(CMD_POP, 32'h0, 32, 0, 0);
		add_op(CMD_CLEAR, 32'hFFFF_FFFF, 63, 2047, 0);
		add_op(CMD_POP, 32'h0, 0, 0, 1);
		add_op(CMD_READ, 32'h0, 0, 0, 0);
		add_op(CMD_PUSH, 32'hAAAA_AAAA, 32, 0, 0);
		add_op(CMD_READ, 32'h0, 0, 31, 0);
		add_op(CMD_CLEAR, 32'h0, 0, 0, 0);
		target = op_backlog.size() + RANDOM_OPS;

		// random episodes with random content
		while (op_backlog.size() < target) begin
			mode   = $urandom_range(0, 9);
			settle = ($urandom_range(0, 9) == 0);
			if (mode <= 3) begin
				// fill, often all the way to an overflow
				hit_full = 1'b0;
				cnt      = 0;
				idx      = ($urandom_range(0, 2) == 0) ? CAP_BITS + WORD_BITS :
					$urandom_range(gen_fill, CAP_BITS);
				while (gen_fill < idx && !hit_full && cnt < 120) begin
					if ($urandom_range(0, 24) == 0) begin
						len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63);
						add_op(CMD_PUSH, $urandom, len, $urandom_range(0, 2047), settle);
					end else if ($urandom_range(0, 7) == 0 && gen_fill > 0) begin
						add_op(CMD_READ, $urandom, $urandom_range(0, 63),
							$urandom_range(0, gen_fill - 1), settle);
					end else begin
						len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) :
							$urandom_range(20, 32);
						hit_full = (len > CAP_BITS - gen_fill);
						add_op(CMD_PUSH, $urandom, len, $urandom_range(0, 2047), settle);
					end
					settle = 1'b0;
					cnt++;
				end
				if (hit_full) begin
					add_op(CMD_READ, $urandom, $urandom_range(0, 63),
						$urandom_range(2040, 2047), 0);
					add_op(CMD_READ, $urandom, $urandom_range(0, 63), gen_fill - 1, 0);
				end
			end else if (mode <= 5) begin
				// read back, mostly in range
				cnt = $urandom_range(8, 30);
				repeat (cnt) begin
					if (gen_fill > 0 && $urandom_range(0, 5) != 0)
						idx = $urandom_range(0, gen_fill - 1);
					else if ($urandom_range(0, 1) == 0)
						idx = gen_fill;
					else
						idx = $urandom_range(0, 2047);
					add_op(CMD_READ, $urandom, $urandom_range(0, 63), idx, settle);
					settle = 1'b0;
				end
			end else if (mode <= 7) begin
				// pop down, sometimes past empty
				if (gen_fill <= 64 && $urandom_range(0, 1) == 0)
					cnt = gen_fill + $urandom_range(1, 3);
				else
					cnt = $urandom_range(3, 40);
				repeat (cnt) begin
					add_op(CMD_POP, $urandom, $urandom_range(0, 63),
						$urandom_range(0, 2047), settle);
					settle = 1'b0;
				end
			end else if (mode == 8) begin
				add_op(CMD_CLEAR, $urandom, $urandom_range(0, 63),
					$urandom_range(0, 2047), settle);
			end else begin
				// noise: any command with any field values
				cnt = $urandom_range(4, 12);
				repeat (cnt) begin
					add_op(CMD_W'($urandom_range(0, 3)), $urandom, $urandom_range(0, 63),
						$urandom_range(0, 2047), settle);
					settle = 1'b0;
				end
			end
		end
		n_total = op_backlog.size();

		// reset, then release on a clock edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent != n_total || n_recv != n_total)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (bitstack_replies.size() != 0) begin
			$error("%0d results still owed at end of run", bitstack_replies.size());
			fail_count++;
		end
		$display("covered %0d transfers: %0d push, %0d pop, %0d read, %0d clear",
			n_total, op_tally[CMD_PUSH], op_tally[CMD_POP], op_tally[CMD_READ],
			op_tally[CMD_CLEAR]);
		$display("outcomes: ok %0d, bad length %0d, out of range %0d, overflow %0d, pop empty %0d",
			status_tally[ST_OK], status_tally[ST_BAD_LENGTH], status_tally[ST_RANGE],
			status_tally[ST_OVERFLOW], status_tally[ST_POP_EMPTY]);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/msbp_pkg.sv
hw/rtl/msbp_ram.sv
hw/rtl/msbp_ctrl.sv
hw/rtl/msbp_dpath.sv
hw/rtl/msb_first_bit_stack_packer.sv
dv/tb_msb_first_bit_stack_packer.sv
